@@ src/route_leg_distance_accumulator_unit_macros.svh @@
// Assertion macros shared by the route leg distance accumulator modules
`ifndef ROUTE_LEG_DISTANCE_ACCUMULATOR_UNIT_MACROS_SVH
`define ROUTE_LEG_DISTANCE_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define RLDA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlda assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define RLDA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlda assertion failed");

`endif

@@ src/rlda_pkg.sv @@
// Types, constants and elaboration-time tables for the route leg distance accumulator
package rlda_pkg;

   localparam int MAX_STEPS = 40;
   localparam int XY_W      = 34;
   localparam int Z_W       = 44;
   localparam int SQ_STEPS  = 32;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
   localparam logic [63:0] RAD_PER_UNIT_Q62 = (PI_Q62 + 64'd1800000000) / 64'd3600000000;
   localparam logic [63:0] HALF_PI_Q40 = ((PI_Q62 + (64'd1 << 21)) >> 22) / 64'd2;
   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
   localparam logic [34:0] FULL_TURN = 35'd7200000000;
   localparam logic [34:0] QUARTER_TURN = 35'd1800000000;
   localparam logic [34:0] HALF_TURN = 35'd3600000000;
   localparam logic [34:0] THREE_QUARTER_TURN = 35'd5400000000;
   localparam logic [63:0] LEG_MUL = 64'd1592752200;
   localparam logic [63:0] LEG_ROUND = 64'd463 << 29;
   // ceil(2^41 / 463): exact quotient for every dividend below 5.7e9
   localparam logic [63:0] LEG_RECIP = 64'd4749510272;
   localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [23:0] LEG_MAX = 24'hFF_FFFF;

   // angle source selects
   localparam logic [2:0] SC_DLAT = 3'd0;
   localparam logic [2:0] SC_DLON = 3'd1;
   localparam logic [2:0] SC_LAT1 = 3'd2;
   localparam logic [2:0] SC_LAT2 = 3'd3;
   // multiplier operand selects
   localparam logic [2:0] MUL_S1S1 = 3'd0;
   localparam logic [2:0] MUL_C1C2 = 3'd1;
   localparam logic [2:0] MUL_TS2  = 3'd2;
   localparam logic [2:0] MUL_LEG  = 3'd3;
   localparam logic [2:0] MUL_ANG  = 3'd4;
   localparam logic [2:0] MUL_DIV  = 3'd5;
   // square root operand selects
   localparam logic [2:0] SQ_H     = 3'd0;
   localparam logic [2:0] SQ_ONE_H = 3'd1;

   typedef struct packed {
      logic signed [30:0] lat_e7;
      logic signed [31:0] lon_e7;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [23:0] leg_milli_nm;
      logic [39:0] total_milli_nm;
      logic [15:0] leg_number;
      logic        route_done;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_FIRST, OP_ANG, OP_QUAD, OP_MUL, OP_ZINIT, OP_ROT, OP_SCST,
      OP_HSET, OP_HADD, OP_SQL, OP_SQS, OP_SQST, OP_VINIT, OP_VEC, OP_C30,
      OP_DIVI, OP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] sel;
      logic [5:0] iter;
   } cmd_type;

   typedef struct packed {
      logic have_prev;
      logic last_point;
      logic out_free;
   } status_type;

   typedef logic [Z_W-1:0] atan_tbl_type [MAX_STEPS];

   // long division by shift and subtract, used only at elaboration
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v, r, b;
      v = val;
      r = '0;
      b = 64'd1 << 62;
      for (int k = 0; k < SQ_STEPS; k++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // atan(2^-i) in Q40 from the alternating series, first entry from pi
   function automatic atan_tbl_type build_atan();
      atan_tbl_type       tbl;
      logic signed [63:0] sum;
      logic [63:0]        v, t;
      int                 sh;
      for (int i = 0; i < MAX_STEPS; i++) begin
         if (i == 0) begin
            v = PI_Q60;
         end else begin
            sum = '0;
            for (int k = 0; k < 32; k++) begin
               sh = i * (2 * k + 1);
               if (sh <= 62) begin
                  t = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
                  if ((k & 1) != 0) sum = sum - $signed(t);
                  else              sum = sum + $signed(t);
               end
            end
            v = sum;
         end
         tbl[i] = Z_W'((v + (64'd1 << 21)) >> 22);
      end
      return tbl;
   endfunction

   // reciprocal of the CORDIC gain in Q30
   function automatic logic [63:0] gain_inv(input int steps);
      logic [63:0] g, gr;
      g = 64'd1 << 60;
      for (int i = 0; i < MAX_STEPS; i++) begin
         if (i < steps && 2 * i <= 62) g = g + (g >> (2 * i));
      end
      gr = isqrt64(g);
      return udiv64((64'd1 << 60) + (gr >> 1), gr);
   endfunction

   localparam atan_tbl_type ATAN_TBL = build_atan();

endpackage

@@ src/rlda_ctrl.sv @@
// Sequencer that steps the shared CORDIC, multiplier and square root
`include "route_leg_distance_accumulator_unit_macros.svh"
module rlda_ctrl import rlda_pkg::*; #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   localparam logic [5:0] LAST_ROT = 6'(CORDIC_STEPS - 1);
   localparam logic [5:0] SQ_LAST  = 6'(SQ_STEPS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_FIRST, S_ANG, S_QUAD, S_ZMUL, S_ZINIT, S_ROT, S_SCST,
      S_M_S1, S_HSET, S_M_C, S_M_T1, S_M_T2, S_HADD, S_SQL, S_SQS, S_SQST,
      S_VINIT, S_VEC, S_C30, S_M_LEG, S_DIVI, S_M_DIV, S_FINISH
   } state_type;

   state_type  state_ff;
   logic [1:0] sel_ff;
   logic [5:0] cnt_ff;
   logic       stall_ff;
   logic       first_go;

   assign req_stall = stall_ff;
   assign first_go  = !sts.last_point || sts.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= '0;
         cnt_ff   <= '0;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CHECK;
                  stall_ff <= 1'b1;
               end
            end
            S_CHECK: begin
               sel_ff   <= '0;
               state_ff <= sts.have_prev ? S_ANG : S_FIRST;
            end
            S_FIRST: begin
               if (first_go) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            S_ANG:   state_ff <= S_QUAD;
            S_QUAD:  state_ff <= S_ZMUL;
            S_ZMUL:  state_ff <= S_ZINIT;
            S_ZINIT: begin
               state_ff <= S_ROT;
               cnt_ff   <= '0;
            end
            S_ROT: begin
               if (cnt_ff == LAST_ROT) state_ff <= S_SCST;
               else                    cnt_ff   <= cnt_ff + 6'd1;
            end
            S_SCST: begin
               if (sel_ff == 2'd3) begin
                  state_ff <= S_M_S1;
               end else begin
                  sel_ff   <= sel_ff + 2'd1;
                  state_ff <= S_ANG;
               end
            end
            S_M_S1: state_ff <= S_HSET;
            S_HSET: state_ff <= S_M_C;
            S_M_C:  state_ff <= S_M_T1;
            S_M_T1: state_ff <= S_M_T2;
            S_M_T2: state_ff <= S_HADD;
            S_HADD: begin
               state_ff <= S_SQL;
               sel_ff   <= '0;
            end
            S_SQL: begin
               state_ff <= S_SQS;
               cnt_ff   <= '0;
            end
            S_SQS: begin
               if (cnt_ff == SQ_LAST) state_ff <= S_SQST;
               else                   cnt_ff   <= cnt_ff + 6'd1;
            end
            S_SQST: begin
               if (sel_ff == 2'd0) begin
                  sel_ff   <= 2'd1;
                  state_ff <= S_SQL;
               end else begin
                  state_ff <= S_VINIT;
               end
            end
            S_VINIT: begin
               state_ff <= S_VEC;
               cnt_ff   <= '0;
            end
            S_VEC: begin
               if (cnt_ff == LAST_ROT) state_ff <= S_C30;
               else                    cnt_ff   <= cnt_ff + 6'd1;
            end
            S_C30:   state_ff <= S_M_LEG;
            S_M_LEG: state_ff <= S_DIVI;
            S_DIVI:  state_ff <= S_M_DIV;
            S_M_DIV: state_ff <= S_FINISH;
            S_FINISH: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.op   = OP_NOP;
      cmd.sel  = {1'b0, sel_ff};
      cmd.iter = cnt_ff;
      unique case (state_ff)
         S_FIRST:  cmd.op = first_go ? OP_FIRST : OP_NOP;
         S_ANG:    cmd.op = OP_ANG;
         S_QUAD:   cmd.op = OP_QUAD;
         S_ZMUL: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_ANG;
         end
         S_ZINIT:  cmd.op = OP_ZINIT;
         S_ROT:    cmd.op = OP_ROT;
         S_SCST:   cmd.op = OP_SCST;
         S_M_S1: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_S1S1;
         end
         S_HSET:   cmd.op = OP_HSET;
         S_M_C: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_C1C2;
         end
         S_M_T1, S_M_T2: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_TS2;
         end
         S_HADD:   cmd.op = OP_HADD;
         S_SQL:    cmd.op = OP_SQL;
         S_SQS:    cmd.op = OP_SQS;
         S_SQST:   cmd.op = OP_SQST;
         S_VINIT:  cmd.op = OP_VINIT;
         S_VEC:    cmd.op = OP_VEC;
         S_C30:    cmd.op = OP_C30;
         S_M_LEG: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_LEG;
         end
         S_DIVI:   cmd.op = OP_DIVI;
         S_M_DIV: begin
            cmd.op  = OP_MUL;
            cmd.sel = MUL_DIV;
         end
         S_FINISH: cmd.op = sts.out_free ? OP_FINISH : OP_NOP;
         default:  cmd.op = OP_NOP;
      endcase
   end

   `RLDA_ASSERT_NEXT(a_accept_stalls, req_valid && !req_stall, req_stall)
   `RLDA_ASSERT_IMPL(a_iter_bound, state_ff == S_ROT || state_ff == S_VEC, cnt_ff <= LAST_ROT)
   `RLDA_ASSERT_NEXT(a_finish_releases, state_ff == S_FINISH && sts.out_free, !req_stall)

endmodule

@@ src/rlda_dpath.sv @@
// Datapath: route state, shared CORDIC, multiplier, square root, reciprocal divide, result register
`include "route_leg_distance_accumulator_unit_macros.svh"
module rlda_dpath import rlda_pkg::*; #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type sts,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(gain_inv(CORDIC_STEPS));

   req_type                  cur_ff;
   logic signed [30:0]       prev_lat_ff;
   logic signed [31:0]       prev_lon_ff;
   logic                     have_prev_ff;
   logic [39:0]              sum_ff;
   logic [15:0]              count_ff;
   logic signed [34:0]       ang_ff;
   logic [1:0]               quad_ff;
   logic signed [2*XY_W-1:0] prod_ff;
   logic signed [XY_W-1:0]   cx_ff, cy_ff;
   logic signed [Z_W-1:0]    cz_ff;
   logic signed [XY_W-1:0]   s1_ff, s2_ff, c1_ff, c2_ff;
   logic signed [63:0]       h_ff;
   logic [63:0]              sq_v_ff, sq_r_ff, sq_b_ff;
   logic [30:0]              a_ff, bq_ff;
   logic [31:0]              c30_ff;
   logic [32:0]              div_n_ff;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   logic signed [34:0]       ang_raw;
   logic [34:0]              quad_off;
   logic [1:0]               quad_code;
   logic signed [XY_W-1:0]   mul_a, mul_b;
   logic [62:0]              zr;
   logic signed [XY_W-1:0]   dx, dy;
   logic signed [Z_W-1:0]    atan_i;
   logic signed [XY_W-1:0]   sin_v, cos_v;
   logic signed [64:0]       hsum;
   logic signed [63:0]       hclamp;
   logic [63:0]              rb;
   logic [40:0]              zc;
   logic [41:0]              c30_sum;
   logic [63:0]              dsum;
   logic [23:0]              leg;
   logic [40:0]              tsum;
   logic [39:0]              tsat;
   logic                     out_free;
   logic                     rsp_load;

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign sts.have_prev  = have_prev_ff;
   assign sts.last_point = cur_ff.last_point;
   assign sts.out_free   = out_free;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign rsp_load       = (cmd.op == OP_FINISH) ||
                           (cmd.op == OP_FIRST && cur_ff.last_point);

   always_comb begin
      case (cmd.sel)
         SC_DLAT: ang_raw = 35'(cur_ff.lat_e7) - 35'(prev_lat_ff);
         SC_DLON: ang_raw = 35'(cur_ff.lon_e7) - 35'(prev_lon_ff);
         SC_LAT1: ang_raw = 35'(prev_lat_ff) <<< 1;
         default: ang_raw = 35'(cur_ff.lat_e7) <<< 1;
      endcase
   end

   // ang_ff already folded into one turn
   always_comb begin
      if (ang_ff >= $signed(THREE_QUARTER_TURN)) begin
         quad_code = 2'd3;
         quad_off  = THREE_QUARTER_TURN;
      end else if (ang_ff >= $signed(HALF_TURN)) begin
         quad_code = 2'd2;
         quad_off  = HALF_TURN;
      end else if (ang_ff >= $signed(QUARTER_TURN)) begin
         quad_code = 2'd1;
         quad_off  = QUARTER_TURN;
      end else begin
         quad_code = 2'd0;
         quad_off  = '0;
      end
   end

   always_comb begin
      case (cmd.sel)
         MUL_S1S1: begin
            mul_a = s1_ff;
            mul_b = s1_ff;
         end
         MUL_C1C2: begin
            mul_a = c1_ff;
            mul_b = c2_ff;
         end
         MUL_TS2: begin
            mul_a = XY_W'(prod_ff >>> 30);
            mul_b = s2_ff;
         end
         MUL_LEG: begin
            mul_a = {2'b00, c30_ff};
            mul_b = XY_W'(LEG_MUL);
         end
         MUL_DIV: begin
            mul_a = {1'b0, div_n_ff};
            mul_b = XY_W'(LEG_RECIP);
         end
         default: begin
            mul_a = ang_ff[XY_W-1:0];
            mul_b = XY_W'(RAD_PER_UNIT_Q62);
         end
      endcase
   end

   assign zr     = (prod_ff[62:0] + 63'd2097152) >> 22;
   assign dx     = cy_ff >>> cmd.iter;
   assign dy     = cx_ff >>> cmd.iter;
   assign atan_i = $signed(ATAN_TBL[cmd.iter]);

   always_comb begin
      case (quad_ff)
         2'd0: begin
            sin_v = cy_ff;
            cos_v = cx_ff;
         end
         2'd1: begin
            sin_v = cx_ff;
            cos_v = -cy_ff;
         end
         2'd2: begin
            sin_v = -cy_ff;
            cos_v = -cx_ff;
         end
         default: begin
            sin_v = -cx_ff;
            cos_v = cy_ff;
         end
      endcase
   end

   // haversine term, clamped to [0, 1.0] in Q60
   always_comb begin
      hsum = 65'(h_ff) + 65'($signed(prod_ff[63:0]));
      if (hsum < 0)                     hclamp = '0;
      else if (hsum > $signed({1'b0, ONE_Q60})) hclamp = $signed(ONE_Q60);
      else                              hclamp = hsum[63:0];
   end

   assign rb = sq_r_ff + sq_b_ff;

   always_comb begin
      if (cz_ff < 0)                                  zc = '0;
      else if (cz_ff > $signed(Z_W'(HALF_PI_Q40)))    zc = 41'(HALF_PI_Q40);
      else                                            zc = cz_ff[40:0];
   end
   assign c30_sum = {zc, 1'b0} + 42'd512;

   assign dsum = prod_ff[63:0] + LEG_ROUND;

   // quotient by 463 sits in the product above bit 41
   assign leg  = (|prod_ff[67:65]) ? LEG_MAX : prod_ff[64:41];
   assign tsum = {1'b0, sum_ff} + {17'd0, leg};
   assign tsat = tsum[40] ? TOTAL_MAX : tsum[39:0];

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) cur_ff <= req_data;

      if (reset) begin
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            OP_NOP: ;
            OP_FIRST: begin
               prev_lat_ff  <= cur_ff.lat_e7;
               prev_lon_ff  <= cur_ff.lon_e7;
               have_prev_ff <= !cur_ff.last_point;
               if (cur_ff.last_point) begin
                  rsp_ff       <= '{leg_milli_nm: '0, total_milli_nm: '0,
                                    leg_number: '0, route_done: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  sum_ff       <= '0;
                  count_ff     <= '0;
               end
            end
            OP_ANG:   ang_ff <= (ang_raw < 0) ? ang_raw + $signed(FULL_TURN) : ang_raw;
            OP_QUAD: begin
               quad_ff <= quad_code;
               ang_ff  <= ang_ff - $signed(quad_off);
            end
            OP_MUL:   prod_ff <= mul_a * mul_b;
            OP_ZINIT: begin
               cz_ff <= Z_W'(zr);
               cx_ff <= GAIN_INV;
               cy_ff <= '0;
            end
            OP_ROT: begin
               if (!cz_ff[Z_W-1]) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - atan_i;
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + atan_i;
               end
            end
            OP_SCST: begin
               case (cmd.sel)
                  SC_DLAT: s1_ff <= sin_v;
                  SC_DLON: s2_ff <= sin_v;
                  SC_LAT1: c1_ff <= cos_v;
                  default: c2_ff <= cos_v;
               endcase
            end
            OP_HSET:  h_ff <= prod_ff[63:0];
            OP_HADD:  h_ff <= hclamp;
            OP_SQL: begin
               sq_v_ff <= (cmd.sel == SQ_ONE_H) ? ONE_Q60 - h_ff : h_ff;
               sq_r_ff <= '0;
               sq_b_ff <= 64'd1 << 62;
            end
            OP_SQS: begin
               if (sq_v_ff >= rb) begin
                  sq_v_ff <= sq_v_ff - rb;
                  sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_b_ff <= sq_b_ff >> 2;
            end
            OP_SQST: begin
               if (cmd.sel == SQ_H) a_ff  <= sq_r_ff[30:0];
               else                 bq_ff <= sq_r_ff[30:0];
            end
            OP_VINIT: begin
               cx_ff <= {3'b000, bq_ff};
               cy_ff <= {3'b000, a_ff};
               cz_ff <= '0;
            end
            OP_VEC: begin
               if (!cy_ff[XY_W-1]) begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + atan_i;
               end else begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - atan_i;
               end
            end
            OP_C30:   c30_ff <= c30_sum[41:10];
            OP_DIVI:  div_n_ff <= dsum[62:30];
            OP_FINISH: begin
               rsp_ff       <= '{leg_milli_nm: leg, total_milli_nm: tsat,
                                 leg_number: count_ff, route_done: cur_ff.last_point};
               rsp_valid_ff <= 1'b1;
               prev_lat_ff  <= cur_ff.lat_e7;
               prev_lon_ff  <= cur_ff.lon_e7;
               if (cur_ff.last_point) begin
                  have_prev_ff <= 1'b0;
                  sum_ff       <= '0;
                  count_ff     <= '0;
               end else begin
                  sum_ff <= tsat;
                  if (count_ff != COUNT_MAX) count_ff <= count_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   `RLDA_ASSERT_NEXT(a_h_clamped, cmd.op == OP_HADD, !h_ff[63] && h_ff <= $signed(ONE_Q60))
   `RLDA_ASSERT_IMPL(a_leg_fits, cmd.op == OP_FINISH, prod_ff[67:65] == 3'd0)
   `RLDA_ASSERT_NEXT(a_finish_loads, cmd.op == OP_FINISH, rsp_valid)

endmodule

@@ src/route_leg_distance_accumulator_unit.sv @@
// Top level of the route leg distance accumulator: sequencer plus datapath
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    req_type  (lat_e7, lon_e7, last_point)
//   rsp_     out        rsp_valid/stall    rsp_type  (leg, total, leg number, done)
//
// A point that closes a leg runs four rotation CORDIC runs, two 32-step square roots, one
// vectoring run and a reciprocal multiply for the divide on one shared iteration unit and
// one multiplier; the next request is not taken until that point is through. Reset is
// synchronous and clears the route. A held result blocks the final write, and with it
// the next request.
module route_leg_distance_accumulator_unit import rlda_pkg::*; #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type sts;

   rlda_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rlda_dpath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/route_leg_distance_accumulator_unit_checker.sv @@
// Request/result monitor with its own leg distance predictor and result scoreboard
module route_leg_distance_accumulator_unit_checker import rlda_pkg::*; #(
   parameter int CORDIC_STEPS = 28
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      legs_pending
);
   localparam longint TURN    = 64'd7200000000;
   localparam longint QUARTER = 64'd1800000000;

   longint          atan_q40 [MAX_STEPS];
   longint          unit_gain_q30;
   longint          last_lat, last_lon;
   bit              point_held;
   longint unsigned dist_sum;
   int unsigned     leg_idx;
   rsp_type         leg_queue [$];

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // sine and cosine of an angle in 5e-8 degree, Q30
   task automatic rotate(input longint ang, output longint s, output longint c);
      longint r, x, y, z, q, dx, dy;
      r = ang % TURN;
      if (r < 0) r += TURN;
      q = r / QUARTER;
      r -= q * QUARTER;
      z = longint'((longint'(unsigned'(r)) * RAD_PER_UNIT_Q62 + (64'd1 << 21)) >> 22);
      x = unit_gain_q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin x -= dx; y += dy; z -= atan_q40[i]; end
         else begin x += dx; y -= dy; z += atan_q40[i]; end
      end
      case (q)
         0: begin s = y;  c = x;  end
         1: begin s = x;  c = -y; end
         2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endtask

   task automatic great_circle(input longint la1, lo1, la2, lo2,
                               output longint unsigned leg);
      longint          s1, s2, c1, c2, unused, h, x, y, z, dx, dy;
      longint unsigned c30;
      rotate(la2 - la1, s1, unused);
      rotate(lo2 - lo1, s2, unused);
      rotate(2 * la1, unused, c1);
      rotate(2 * la2, unused, c2);
      h = s1 * s1 + (((c1 * c2) >>> 30) * s2 >>> 30) * s2;
      if (h < 0) h = 0;
      if (h > longint'(ONE_Q60)) h = ONE_Q60;
      x = root_floor(ONE_Q60 - h);
      y = root_floor(h);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin x += dx; y -= dy; z += atan_q40[i]; end
         else begin x -= dx; y += dy; z -= atan_q40[i]; end
      end
      if (z < 0) z = 0;
      if (z > longint'(HALF_PI_Q40)) z = HALF_PI_Q40;
      c30 = (longint'(unsigned'(z)) * 2 + 512) >> 10;
      leg = (c30 * 64'd1592752200 + (64'd463 << 29)) / (64'd463 << 30);
      if (leg > 64'hFFFFFF) leg = 64'hFFFFFF;
   endtask

   initial begin
      longint          acc, t;
      longint unsigned g, gr;
      int              sh;
      for (int i = 0; i < MAX_STEPS; i++) begin
         if (i == 0) begin
            acc = PI_Q60;
         end else begin
            acc = 0;
            for (int k = 0; k < 32; k++) begin
               sh = i * (2 * k + 1);
               if (sh > 62) break;
               t = (64'd1 << (62 - sh)) / (2 * k + 1);
               acc = (k & 1) ? acc - t : acc + t;
            end
         end
         atan_q40[i] = longint'((longint'(unsigned'(acc)) + (64'd1 << 21)) >> 22);
      end
      g = 64'd1 << 60;
      for (int i = 0; i < CORDIC_STEPS; i++) if (2 * i <= 62) g += g >> (2 * i);
      gr = root_floor(g);
      unit_gain_q30 = ((64'd1 << 60) + gr / 2) / gr;
   end

   always @(posedge clock) begin
      rsp_type         want, got;
      longint          lat, lon;
      longint unsigned leg;
      if (reset) begin
         fail_count = 0;
         point_held = 0;
         last_lat   = 0;
         last_lon   = 0;
         dist_sum   = 0;
         leg_idx    = 0;
         leg_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (leg_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               want = leg_queue.pop_front();
               if (got.leg_milli_nm !== want.leg_milli_nm ||
                   got.total_milli_nm !== want.total_milli_nm ||
                   got.leg_number !== want.leg_number ||
                   got.route_done !== want.route_done) begin
                  fail_count++;
                  $display("%0t: result mismatch expected leg %0d total %0d num %0d done %0b",
                           $time, want.leg_milli_nm, want.total_milli_nm,
                           want.leg_number, want.route_done);
                  $display("%0t:                   actual leg %0d total %0d num %0d done %0b",
                           $time, got.leg_milli_nm, got.total_milli_nm,
                           got.leg_number, got.route_done);
               end
            end
         end
         if (req_valid && !req_stall) begin
            lat = req_data.lat_e7;
            lon = req_data.lon_e7;
            if (!point_held) begin
               last_lat   = lat;
               last_lon   = lon;
               point_held = 1;
               if (req_data.last_point) begin
                  want = '0;
                  want.route_done = 1'b1;
                  leg_queue.push_back(want);
                  point_held = 0;
               end
            end else begin
               great_circle(last_lat, last_lon, lat, lon, leg);
               want.leg_milli_nm = leg[23:0];
               want.leg_number   = leg_idx[15:0];
               if (leg_idx < 65535) leg_idx++;
               dist_sum += leg;
               if (dist_sum > TOTAL_MAX) dist_sum = TOTAL_MAX;
               want.total_milli_nm = dist_sum[39:0];
               want.route_done     = req_data.last_point;
               leg_queue.push_back(want);
               last_lat = lat;
               last_lon = lon;
               if (req_data.last_point) begin
                  point_held = 0;
                  dist_sum   = 0;
                  leg_idx    = 0;
               end
            end
         end
      end
      legs_pending = leg_queue.size();
   end
endmodule

@@ dv/route_leg_distance_accumulator_unit_tb.sv @@
// Testbench top: request stimulus, result backpressure and verdict
module route_leg_distance_accumulator_unit_tb;
   import rlda_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      legs_pending;
   int      sent = 0;
   int      results_seen = 0;
   int      hold = 0;

   route_leg_distance_accumulator_unit uut (.*);
   route_leg_distance_accumulator_unit_checker chk (.*);

   initial forever #6 clock = ~clock;

   initial begin
      #40000000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_point(input logic signed [30:0] lat, input logic signed [31:0] lon,
                             input logic last);
      int gap;
      gap = (sent >= 600 && sent < 800) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= '{lat, lon, last};
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [30:0] rand_lat(input bit wild);
      if (wild) return 31'($urandom);
      return 31'($urandom_range(0, 1800000000) - 900000000);
   endfunction

   function automatic logic signed [31:0] rand_lon(input bit wild);
      if (wild) return 32'($urandom);
      return 32'(longint'($urandom_range(0, 3600000000)) - 1800000000);
   endfunction

   // receiver: random stall per result, one long hold-off to back up the block, one stall-free stretch
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_seen == 200) hold = 1500;
            else if (results_seen >= 700 && results_seen < 900) hold = 0;
            else hold = $urandom_range(0, 3);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1;
            hold--;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      int  len;
      bit  wild;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // single-point route
      send_point(0, 0, 1);
      // extremes of the nominal range, antipode and a zero-length leg
      send_point(900000000, 1800000000, 0);
      send_point(-900000000, -1800000000, 0);
      send_point(-900000000, -1800000000, 0);
      send_point(0, 0, 0);
      send_point(0, 1800000000, 0);
      send_point(0, -1800000000, 1);
      // raw field extremes, out of range angles
      send_point(31'sh40000000, 32'sh80000000, 0);
      send_point(31'sh3FFFFFFF, 32'sh7FFFFFFF, 0);
      send_point(31'sh40000000, 32'sh7FFFFFFF, 0);
      send_point(-1, -1, 0);
      send_point(1, 1, 1);
      send_point(450000000, 100000000, 1);
      send_point(123456789, -98765432, 0);
      send_point(123456790, -98765431, 1);
      while (sent < 1600) begin
         len  = $urandom_range(1, 8);
         wild = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++)
            send_point(rand_lat(wild), rand_lon(wild), i == len - 1);
      end
      req_valid <= 0;
      while (legs_pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && legs_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
